/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lz77m_pkg.sv */
// Types, constants and helper functions shared by the match finder.
package lz77m_pkg;

  localparam int WINDOW_SIZE_DEF     = 32768;
  localparam int MAX_CHAIN_DEF       = 256;
  localparam int MAX_MATCH_DEF       = 258;
  localparam int LOOKAHEAD_DEPTH_DEF = 512;

  // Chain heads are indexed by the full two-byte key.
  localparam int HEAD_DEPTH  = 65536;
  localparam int KEY_W       = 16;
  localparam int POS_W       = 16;
  localparam int HEAD_W      = POS_W + 1;
  localparam int DIST_W      = 16;
  localparam int LEN_W       = 9;
  localparam int RANK_ARG_W  = 13;
  localparam int QUEUE_DEPTH = 4;

  // Input word function codes.
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic              is_match;
    logic [7:0]        literal;
    logic [LEN_W-1:0]  match_length;
    logic [DIST_W-1:0] match_distance;
    logic              last_of_block;
  } out_word_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic       valid;
    logic       drain;
    logic [7:0] data;
  } qhead_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic pop;
    logic clear_done;
  } back_stat_t;

  // Early-exit length quota for a candidate of the given rank.
  function automatic logic [LEN_W-1:0] quota(input logic [RANK_ARG_W-1:0] rank);
    logic [8:0]  r;
    logic [17:0] sq;
    logic [20:0] s7;
    r  = (rank < RANK_ARG_W'(256)) ? 9'(RANK_ARG_W'(256) - rank) : 9'd0;
    sq = 18'(r) * 18'(r);
    s7 = {sq, 3'b000} - 21'(sq);
    return LEN_W'((s7 >> 11) + 21'd32);
  endfunction

endpackage

/* hdl/lz77m_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lz77m_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lz77m_front.sv */
// Front end: accepts input words, tags them and queues them for the back end.
module lz77m_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_ready,
  input  lz77m_pkg::in_word_t   src_word,
  output lz77m_pkg::qhead_t     qhead,
  input  lz77m_pkg::back_stat_t bstat
);

  localparam int QW = $clog2(lz77m_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(lz77m_pkg::QUEUE_DEPTH + 1);

  lz77m_pkg::in_word_t qbuf [lz77m_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wptr;
  logic [QW-1:0] rptr;
  logic [CW-1:0] fill;
  logic          push;

  assign src_ready = bstat.clear_done && (fill < CW'(lz77m_pkg::QUEUE_DEPTH));
  assign push      = src_valid && src_ready;

  always_comb begin
    qhead.valid = (fill != '0);
    qhead.drain = (qbuf[rptr].func == lz77m_pkg::FUNC_DRAIN);
    qhead.data  = qbuf[rptr].data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QW'(lz77m_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (bstat.pop) begin
        rptr <= (rptr == QW'(lz77m_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !bstat.pop) begin
        fill <= fill + 1'b1;
      end else if (!push && bstat.pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qbuf[wptr] <= src_word;
    end
  end

endmodule

/* hdl/lz77m_back.sv */
// Back end: lookahead fill, hash-chain search, chain update and token output.
module lz77m_back #(
  parameter int WINDOW_SIZE     = lz77m_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_CHAIN       = lz77m_pkg::MAX_CHAIN_DEF,
  parameter int MAX_MATCH       = lz77m_pkg::MAX_MATCH_DEF,
  parameter int LOOKAHEAD_DEPTH = lz77m_pkg::LOOKAHEAD_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lz77m_pkg::qhead_t     qhead,
  output lz77m_pkg::back_stat_t bstat,
  output logic                  tok_valid,
  input  logic                  tok_ready,
  output lz77m_pkg::out_word_t  tok_word
);

  localparam int WA  = $clog2(WINDOW_SIZE);
  localparam int LAW = $clog2(LOOKAHEAD_DEPTH);
  localparam int CW  = $clog2(LOOKAHEAD_DEPTH + 1);
  localparam int RKW = $clog2(MAX_CHAIN + 1);
  localparam int LW  = lz77m_pkg::LEN_W;
  localparam int PW  = lz77m_pkg::POS_W;
  localparam int HW  = lz77m_pkg::HEAD_W;
  localparam int KW  = lz77m_pkg::KEY_W;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_KEY   = 4'd2;
  localparam logic [3:0] ST_KEY2  = 4'd3;
  localparam logic [3:0] ST_HEAD  = 4'd4;
  localparam logic [3:0] ST_CAND  = 4'd5;
  localparam logic [3:0] ST_CMP   = 4'd6;
  localparam logic [3:0] ST_EVAL  = 4'd7;
  localparam logic [3:0] ST_LINK  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_A0    = 4'd10;
  localparam logic [3:0] ST_A1    = 4'd11;
  localparam logic [3:0] ST_A2    = 4'd12;
  localparam logic [3:0] ST_A3    = 4'd13;
  localparam logic [3:0] ST_A4    = 4'd14;
  localparam logic [3:0] ST_EMIT  = 4'd15;

  logic [3:0]    state;
  logic [KW-1:0] clr_addr;
  logic          clear_done;

  logic [PW-1:0] sp;
  logic [CW-1:0] count;
  logic [CW-1:0] ri;
  logic          ended;
  logic [WA-1:0] win_slot;
  logic          win_full;

  logic [7:0]    lit;
  logic [7:0]    ka0;
  logic [7:0]    ka1;
  logic [7:0]    w0;
  logic [KW-1:0] okey;
  logic          fwd;

  logic [16:0]    d;
  logic [WA-1:0]  wbase;
  logic [WA-1:0]  wa;
  logic [LAW-1:0] fa;
  logic [LAW-1:0] lb;
  logic [LW-1:0]  ia;
  logic [LW-1:0]  i;
  logic           cmp_v;
  logic           sel_la;
  logic [LW-1:0]  q;
  logic [RKW-1:0] rank;
  logic [LW-1:0]  best;
  logic [LW-1:0]  len;
  logic [15:0]    best_dist;
  logic [LW-1:0]  limit;
  logic [LW-1:0]  adv_left;
  logic           ism;

  // RAM ports
  logic           la_we;
  logic [LAW-1:0] la_a_raddr, la_b_raddr;
  logic [7:0]     la_a_rdata, la_b_rdata;
  logic           win_we;
  logic [WA-1:0]  win_raddr;
  logic [7:0]     win_rdata;
  logic           hd_we;
  logic [KW-1:0]  hd_waddr, hd_raddr;
  logic [HW-1:0]  hd_wdata, hd_rdata;
  logic           lk_we;
  logic [15:0]    lk_wdata, lk_rdata;

  // Derived values
  logic [CW-1:0]  ri_p1;
  logic [CW-1:0]  remaining;
  logic [WA-1:0]  ws_p1;
  logic [WA-1:0]  wa_p1;
  logic [KW-1:0]  nkey;
  logic           evict;
  logic           hashit;
  logic [PW-1:0]  dh;
  logic [15:0]    new_link;
  logic [PW-1:0]  d_init;
  logic [16:0]    base_calc;
  logic           eq;
  logic [LW-1:0]  i_inc;
  logic           take;
  logic [LW-1:0]  len_new;
  logic [16:0]    d_next;

  assign ri_p1     = ri + 1'b1;
  assign remaining = count - ri;
  assign ws_p1     = (win_slot == WA'(WINDOW_SIZE - 1)) ? '0 : win_slot + 1'b1;
  assign wa_p1     = (wa == WA'(WINDOW_SIZE - 1)) ? '0 : wa + 1'b1;
  assign nkey      = {ka0, ka1};
  assign evict     = win_full && (hd_rdata == {1'b1, PW'(sp - PW'(WINDOW_SIZE))});
  assign hashit    = (ri_p1 < count);
  assign dh        = sp - hd_rdata[PW-1:0];
  assign new_link  = (!fwd && hd_rdata[HW-1] && dh != '0 && {1'b0, dh} <= 17'(WINDOW_SIZE))
                     ? dh : 16'd0;
  assign d_init    = sp - hd_rdata[PW-1:0];
  assign base_calc = (17'(win_slot) >= d) ? 17'(win_slot) - d
                                          : 17'(win_slot) + 17'(WINDOW_SIZE) - d;
  assign eq        = (la_a_rdata == (sel_la ? la_b_rdata : win_rdata));
  assign i_inc     = i + 1'b1;
  assign take      = (i > best);
  assign len_new   = take ? i : len;
  assign d_next    = d + 17'(lk_rdata);

  assign bstat.pop        = (state == ST_IDLE) && qhead.valid;
  assign bstat.clear_done = clear_done;

  always_comb begin
    la_a_raddr = ri[LAW-1:0];
    la_b_raddr = ri_p1[LAW-1:0];
    win_raddr  = win_slot;
    hd_raddr   = {la_a_rdata, la_b_rdata};
    la_we      = 1'b0;
    win_we     = 1'b0;
    hd_we      = 1'b0;
    hd_waddr   = nkey;
    hd_wdata   = {1'b1, sp};
    lk_we      = 1'b0;
    lk_wdata   = new_link;
    case (state)
      ST_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_addr;
        hd_wdata = '0;
      end
      ST_IDLE: begin
        la_we = qhead.valid && !qhead.drain && !ended &&
                (count < CW'(LOOKAHEAD_DEPTH));
      end
      ST_CMP: begin
        la_a_raddr = fa;
        la_b_raddr = lb;
        win_raddr  = wa;
      end
      ST_A1: begin
        win_raddr = ws_p1;
      end
      ST_A2: begin
        hd_raddr = {w0, win_rdata};
      end
      ST_A3: begin
        hd_raddr = nkey;
        hd_we    = evict;
        hd_waddr = okey;
        hd_wdata = '0;
      end
      ST_A4: begin
        hd_we  = hashit;
        lk_we  = hashit;
        win_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Two lookahead copies give two independent read ports.
  lz77m_ram #(.WIDTH(8), .DEPTH(LOOKAHEAD_DEPTH)) u_la_a (
    .clk(clk), .we(la_we), .waddr(count[LAW-1:0]), .wdata(qhead.data),
    .raddr(la_a_raddr), .rdata(la_a_rdata)
  );

  lz77m_ram #(.WIDTH(8), .DEPTH(LOOKAHEAD_DEPTH)) u_la_b (
    .clk(clk), .we(la_we), .waddr(count[LAW-1:0]), .wdata(qhead.data),
    .raddr(la_b_raddr), .rdata(la_b_rdata)
  );

  lz77m_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_win (
    .clk(clk), .we(win_we), .waddr(win_slot), .wdata(ka0),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  lz77m_ram #(.WIDTH(HW), .DEPTH(lz77m_pkg::HEAD_DEPTH)) u_heads (
    .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .raddr(hd_raddr), .rdata(hd_rdata)
  );

  lz77m_ram #(.WIDTH(16), .DEPTH(WINDOW_SIZE)) u_links (
    .clk(clk), .we(lk_we), .waddr(win_slot), .wdata(lk_wdata),
    .raddr(wbase), .rdata(lk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clear_done <= 1'b0;
      sp         <= '0;
      count      <= '0;
      ri         <= '0;
      ended      <= 1'b0;
      win_slot   <= '0;
      win_full   <= 1'b0;
      tok_valid  <= 1'b0;
      cmp_v      <= 1'b0;
    end else begin
      if (tok_valid && tok_ready && state != ST_EMIT) begin
        tok_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == KW'(lz77m_pkg::HEAD_DEPTH - 1)) begin
            clear_done <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (qhead.valid) begin
            if (!qhead.drain) begin
              if (la_we) begin
                count <= count + 1'b1;
              end
            end else if (ri >= count) begin
              count <= '0;
              ri    <= '0;
              ended <= 1'b0;
            end else begin
              ended     <= 1'b1;
              best      <= LW'(2);
              len       <= '0;
              best_dist <= '0;
              state     <= ST_KEY;
            end
          end
        end
        ST_KEY: begin
          state <= ST_KEY2;
        end
        ST_KEY2: begin
          lit   <= la_a_rdata;
          limit <= (remaining < CW'(MAX_MATCH)) ? LW'(remaining) : LW'(MAX_MATCH);
          state <= (remaining < CW'(3)) ? ST_FIN : ST_HEAD;
        end
        ST_HEAD: begin
          d    <= {1'b0, d_init};
          rank <= '0;
          if (!hd_rdata[HW-1] || d_init == '0 ||
              {1'b0, d_init} > 17'(WINDOW_SIZE)) begin
            state <= ST_FIN;
          end else begin
            state <= ST_CAND;
          end
        end
        ST_CAND: begin
          wbase <= WA'(base_calc);
          wa    <= WA'(base_calc);
          q     <= lz77m_pkg::quota(lz77m_pkg::RANK_ARG_W'(rank));
          ia    <= '0;
          i     <= '0;
          cmp_v <= 1'b0;
          fa    <= ri[LAW-1:0];
          lb    <= ri[LAW-1:0];
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (ia < limit) begin
            fa    <= fa + 1'b1;
            ia    <= ia + 1'b1;
            cmp_v <= 1'b1;
            if (17'(ia) < d) begin
              wa     <= wa_p1;
              sel_la <= 1'b0;
            end else begin
              lb     <= lb + 1'b1;
              sel_la <= 1'b1;
            end
          end else begin
            cmp_v <= 1'b0;
          end
          if (cmp_v) begin
            if (eq) begin
              i <= i_inc;
              if (i_inc == limit) begin
                state <= ST_EVAL;
              end
            end else begin
              state <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          cmp_v <= 1'b0;
          if (take) begin
            best      <= i;
            len       <= i;
            best_dist <= d[15:0];
          end
          if (len_new == LW'(MAX_MATCH) || len_new >= q) begin
            state <= ST_FIN;
          end else begin
            state <= ST_LINK;
          end
        end
        ST_LINK: begin
          if (lk_rdata == '0 ||
              (lz77m_pkg::RANK_ARG_W'(rank) + 1'b1) >=
                lz77m_pkg::RANK_ARG_W'(MAX_CHAIN) ||
              d_next > 17'(WINDOW_SIZE)) begin
            state <= ST_FIN;
          end else begin
            d     <= d_next;
            rank  <= rank + 1'b1;
            state <= ST_CAND;
          end
        end
        ST_FIN: begin
          ism      <= (len >= LW'(4));
          adv_left <= (len >= LW'(4)) ? len : LW'(1);
          state    <= ST_A0;
        end
        ST_A0: begin
          state <= ST_A1;
        end
        ST_A1: begin
          ka0   <= la_a_rdata;
          ka1   <= la_b_rdata;
          w0    <= win_rdata;
          state <= ST_A2;
        end
        ST_A2: begin
          okey  <= {w0, win_rdata};
          state <= ST_A3;
        end
        ST_A3: begin
          fwd   <= evict && (okey == nkey);
          state <= ST_A4;
        end
        ST_A4: begin
          sp       <= sp + 1'b1;
          ri       <= ri_p1;
          win_slot <= ws_p1;
          if (win_slot == WA'(WINDOW_SIZE - 1)) begin
            win_full <= 1'b1;
          end
          adv_left <= adv_left - 1'b1;
          state    <= (adv_left == LW'(1)) ? ST_EMIT : ST_A0;
        end
        ST_EMIT: begin
          if (!tok_valid || tok_ready) begin
            tok_valid               <= 1'b1;
            tok_word.is_match       <= ism;
            tok_word.literal        <= ism ? 8'd0 : lit;
            tok_word.match_length   <= ism ? len : '0;
            tok_word.match_distance <= ism ? best_dist : '0;
            tok_word.last_of_block  <= (ri >= count);
            if (ri >= count) begin
              count <= '0;
              ri    <= '0;
              ended <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/lz77_hash_chain_matcher.sv */
// Top level of the LZ77 hash-chain match finder: front queue plus search back end.
//
//   Channel   Signals                       Word type    Direction
//   src       src_valid src_ready src_word  in_word_t    into the block
//   tok       tok_valid tok_ready tok_word  out_word_t   out of the block
//
// A data word is popped and written into the lookahead buffer unless it is full
// or a block is draining. A drain word steps through key and head lookup, then
// per candidate through setup, byte compares, evaluation and the chain link,
// then one hash-chain update per byte the token covers, then settle and emit;
// the one read port on the chain head and window memories keeps these steps serial.
// After reset all 65536 chain heads are cleared, one entry a cycle,
// and src_ready stays low until the pass ends.
// A four-word queue keeps taking input while the back end searches, and the
// token register keeps its word until tok_ready, so either side may stall.
`include "assert_macros.svh"

module lz77_hash_chain_matcher #(
  parameter int WINDOW_SIZE     = lz77m_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_CHAIN       = lz77m_pkg::MAX_CHAIN_DEF,
  parameter int MAX_MATCH       = lz77m_pkg::MAX_MATCH_DEF,
  parameter int LOOKAHEAD_DEPTH = lz77m_pkg::LOOKAHEAD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  lz77m_pkg::in_word_t  src_word,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output lz77m_pkg::out_word_t tok_word
);

  // Queue head handed to the back end, and its pop and clear status back.
  lz77m_pkg::qhead_t     qhead;
  lz77m_pkg::back_stat_t bstat;

  // The front end only buffers; all block state lives in the back end.
  lz77m_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .qhead     (qhead),
    .bstat     (bstat)
  );

  // The back end walks the chains and writes each token into its output register.
  lz77m_back #(
    .WINDOW_SIZE     (WINDOW_SIZE),
    .MAX_CHAIN       (MAX_CHAIN),
    .MAX_MATCH       (MAX_MATCH),
    .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .qhead     (qhead),
    .bstat     (bstat),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_word  (tok_word)
  );

  // Nothing moves on either channel until the head clear pass is finished.
  `CHK_IMPLY(a_quiet_in_clear, !bstat.clear_done, !tok_valid && !src_ready, "activity during head clear")
  // Once the clear pass ends it never restarts without reset.
  `CHK_NEXT(a_clear_sticky, bstat.clear_done, bstat.clear_done, "clear done dropped")
  // A match token carries a legal length and distance.
  `CHK_IMPLY(a_match_range, tok_valid && tok_word.is_match, tok_word.match_length >= 9'd4 && tok_word.match_length <= 9'(MAX_MATCH) && tok_word.match_distance != 16'd0 && 17'(tok_word.match_distance) <= 17'(WINDOW_SIZE), "match token out of range")
  // A literal token has zero length and distance.
  `CHK_IMPLY(a_literal_zero, tok_valid && !tok_word.is_match, tok_word.match_length == 9'd0 && tok_word.match_distance == 16'd0, "literal token with length or distance")

endmodule

/* test/tb_top.sv */
// Testbench for the LZ77 hash-chain match finder, with a self-checking scoreboard.
`timescale 1ns / 100ps

module tb_top;

  localparam int WIN   = 32768;
  localparam int LA    = 512;
  localparam int CHAIN = 256;
  localparam int MMAX  = 258;
  localparam int HOLD_CYCLES = 3000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 src_valid = 1'b0;
  logic                 src_ready;
  lz77m_pkg::in_word_t  src_word = '0;
  logic                 tok_valid;
  logic                 tok_ready = 1'b0;
  lz77m_pkg::out_word_t tok_word;

  lz77_hash_chain_matcher dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .src_word(src_word),
    .tok_valid(tok_valid), .tok_ready(tok_ready), .tok_word(tok_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the match finder's state.
  logic [7:0]  hist_bytes [WIN];
  logic [16:0] key_heads  [65536];
  logic [15:0] hop_dists  [WIN];
  logic [7:0]  block_bytes[LA];
  int unsigned pos_now, blk_count, blk_read, hist_slot, hist_fill;
  bit          blk_closed;

  lz77m_pkg::in_word_t  word_queue[$];
  lz77m_pkg::out_word_t token_queue[$];
  int unsigned words_sent, tokens_seen, matches_seen, mismatches, blocks_made;
  int unsigned src_idle_pct, tok_idle_pct;
  int unsigned hold_left;
  bit          hold_done;

  function automatic int unsigned stop_len(int unsigned rank);
    int unsigned r;
    r = (rank < 256) ? 256 - rank : 0;
    return ((r * r * 7) >> 11) + 32;
  endfunction

  function automatic logic [7:0] behind(int unsigned i, int unsigned d);
    if (i < d)
      return hist_bytes[(hist_slot + WIN - d + i) % WIN];
    return block_bytes[(blk_read + i - d) % LA];
  endfunction

  // Walk the chain for the current key and return the best length/distance.
  function automatic void walk_chain(output int unsigned len, output int unsigned mdist);
    int unsigned left, d, rank, lim, best, i, hop;
    logic [16:0] h;
    len = 0;
    mdist = 0;
    best = 2;
    left = blk_count - blk_read;
    if (left < 3)
      return;
    h = key_heads[{block_bytes[blk_read], block_bytes[blk_read + 1]}];
    if (!h[16])
      return;
    d = (pos_now - h[15:0]) & 16'hFFFF;
    lim = (left < MMAX) ? left : MMAX;
    for (rank = 0; rank < CHAIN && d >= 1 && d <= WIN; rank++) begin
      i = 0;
      while (i < lim && block_bytes[blk_read + i] == behind(i, d))
        i++;
      if (i > best) begin
        best = i;
        len = i;
        mdist = d;
      end
      if (len == MMAX || len >= stop_len(rank))
        break;
      hop = hop_dists[(hist_slot + WIN - d) % WIN];
      if (hop == 0)
        break;
      d += hop;
    end
    if (len < 4) begin
      len = 0;
      mdist = 0;
    end
  endfunction

  // Move one byte from the block into the history, updating its chain.
  function automatic void consume_byte();
    logic [15:0] key;
    logic [16:0] h;
    int unsigned dh, hop;
    if (hist_fill >= WIN) begin
      key = {hist_bytes[hist_slot], hist_bytes[(hist_slot + 1) % WIN]};
      if (key_heads[key] == {1'b1, 16'((pos_now - WIN) & 16'hFFFF)})
        key_heads[key] = '0;
    end
    if (blk_read + 1 < blk_count) begin
      hop = 0;
      key = {block_bytes[blk_read], block_bytes[blk_read + 1]};
      h = key_heads[key];
      if (h[16]) begin
        dh = (pos_now - h[15:0]) & 16'hFFFF;
        if (dh >= 1 && dh <= WIN)
          hop = dh;
      end
      hop_dists[hist_slot] = 16'(hop);
      key_heads[key] = {1'b1, 16'(pos_now & 16'hFFFF)};
    end
    hist_bytes[hist_slot] = block_bytes[blk_read];
    hist_slot = (hist_slot + 1) % WIN;
    blk_read++;
    pos_now++;
    if (hist_fill < WIN)
      hist_fill++;
  endfunction

  // Apply one accepted word; returns 1 with the token when it yields one.
  function automatic bit tokenize(lz77m_pkg::in_word_t w, output lz77m_pkg::out_word_t t);
    int unsigned len, mdist, n;
    logic [7:0]  lit;
    t = '0;
    if (w.func == lz77m_pkg::FUNC_DATA) begin
      if (!blk_closed && blk_count < LA) begin
        block_bytes[blk_count] = w.data_byte;
        blk_count++;
      end
      return 1'b0;
    end
    if (blk_read >= blk_count) begin
      blk_count = 0;
      blk_read = 0;
      blk_closed = 1'b0;
      return 1'b0;
    end
    blk_closed = 1'b1;
    lit = block_bytes[blk_read];
    walk_chain(len, mdist);
    n = (len != 0) ? len : 1;
    repeat (n) consume_byte();
    t.is_match       = (len != 0);
    t.literal        = (len != 0) ? 8'd0 : lit;
    t.match_length   = lz77m_pkg::LEN_W'(len);
    t.match_distance = lz77m_pkg::DIST_W'(mdist);
    t.last_of_block  = (blk_read >= blk_count);
    if (t.last_of_block) begin
      blk_count = 0;
      blk_read = 0;
      blk_closed = 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue a block of n bytes from a small alphabet (0 = any byte), then drains.
  task automatic add_block(int unsigned n, int unsigned alpha, bit noisy);
    lz77m_pkg::in_word_t w;
    logic [7:0]          base;
    base = 8'($urandom);
    for (int unsigned k = 0; k < n; k++) begin
      w.func = lz77m_pkg::FUNC_DATA;
      w.data_byte = (alpha == 0) ? 8'($urandom) : base ^ 8'($urandom_range(alpha - 1));
      word_queue.push_back(w);
    end
    for (int unsigned k = 0; k <= n; k++) begin
      w.func = lz77m_pkg::FUNC_DRAIN;
      w.data_byte = 8'($urandom);
      word_queue.push_back(w);
      // A stray byte after the first drain word is ignored while the block still drains.
      if (noisy && k == 0) begin
        w.func = lz77m_pkg::FUNC_DATA;
        word_queue.push_back(w);
      end
    end
    blocks_made++;
  endtask

  // Sender: offers the next word, holding it until accepted.
  always @(posedge clk) begin
    bit nv;
    nv = src_valid;
    if (rst) begin
      nv = 1'b0;
    end else if (!src_valid || src_ready) begin
      nv = 1'b0;
      if (word_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nv = 1'b1;
        src_word <= word_queue.pop_front();
      end
    end
    src_valid <= nv;
  end

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && words_sent >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk)
    tok_ready <= !rst && hold_left == 0 && $urandom_range(99) >= tok_idle_pct;

  // Scoreboard: check tokens first, then predict from the accepted input word.
  always @(posedge clk) begin
    lz77m_pkg::out_word_t exp_tok;
    lz77m_pkg::out_word_t new_tok;
    if (!rst && tok_valid && tok_ready) begin
      tokens_seen++;
      if (token_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected token %p", tok_word);
      end else begin
        exp_tok = token_queue.pop_front();
        if (exp_tok.is_match) matches_seen++;
        if (tok_word.is_match !== exp_tok.is_match || tok_word.literal !== exp_tok.literal ||
            tok_word.match_length !== exp_tok.match_length ||
            tok_word.match_distance !== exp_tok.match_distance ||
            tok_word.last_of_block !== exp_tok.last_of_block) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: token %0d expected %p got %p", tokens_seen, exp_tok, tok_word);
        end
      end
    end
    if (!rst && src_valid && src_ready) begin
      words_sent++;
      if (tokenize(src_word, new_tok))
        token_queue.push_back(new_tok);
    end
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    lz77m_pkg::in_word_t w;
    foreach (key_heads[k]) key_heads[k] = '0;
    foreach (hop_dists[k]) hop_dists[k] = '0;
    foreach (hist_bytes[k]) hist_bytes[k] = '0;
    foreach (block_bytes[k]) block_bytes[k] = '0;
    src_idle_pct = 38;
    tok_idle_pct = 54;

    // Directed part: empty drain, extreme bytes, tiny blocks, long runs, overflow.
    w.func = lz77m_pkg::FUNC_DRAIN;
    w.data_byte = 8'hFF;
    word_queue.push_back(w);
    w.func = lz77m_pkg::FUNC_DATA;
    w.data_byte = 8'h00;
    word_queue.push_back(w);
    w.func = lz77m_pkg::FUNC_DRAIN;
    word_queue.push_back(w);
    w.func = lz77m_pkg::FUNC_DATA;
    w.data_byte = 8'hFF;
    word_queue.push_back(w);
    word_queue.push_back(w);
    w.func = lz77m_pkg::FUNC_DRAIN;
    repeat (3) word_queue.push_back(w);
    add_block(3, 1, 1'b0);
    add_block(8, 1, 1'b1);

    // A run longer than the lookahead buffer: the excess bytes are dropped and
    // the rest drains as a literal and then long matches, the first of maximum length.
    w.func = lz77m_pkg::FUNC_DATA;
    w.data_byte = 8'h5A;
    repeat (LA + 3) word_queue.push_back(w);
    w.func = lz77m_pkg::FUNC_DRAIN;
    repeat (6) word_queue.push_back(w);
    blocks_made++;

    // Random part: mostly repetitive blocks so chains and matches get deep.
    while (word_queue.size() < 880) begin
      case ($urandom_range(9))
        0: add_block($urandom_range(1, 6), 0, 1'b1);
        1: add_block($urandom_range(60, 100), $urandom_range(1, 3), 1'b0);
        default: add_block($urandom_range(4, 40), $urandom_range(1, 4), $urandom_range(7) == 0);
      endcase
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (words_sent >= 300);
    src_idle_pct = 54;
    tok_idle_pct = 38;
    wait (words_sent >= 600);
    src_idle_pct = 0;
    tok_idle_pct = 0;
    wait (word_queue.size() == 0 && !src_valid && token_queue.size() == 0);
    repeat (2000) @(posedge clk);

    $display("Covered %0d blocks: %0d words in, %0d tokens out, %0d of them matches.",
             blocks_made, words_sent, tokens_seen, matches_seen);
    if (mismatches == 0 && token_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d tokens missing", mismatches, token_queue.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
